// ===== rtl/atip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atip_pkg
// Shared types and constants for the aux tag index parser.
// ----------------------------------------------------------------------------
package atip_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned TAG_W  = 16;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned SKIP_W = 34;

    localparam logic [KIND_W-1:0] KIND_TAG     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BADTYPE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BADSUB  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRUNC   = 3'd4;

    localparam logic [7:0] CH_UA = 8'h41; // A
    localparam logic [7:0] CH_LA = 8'h61; // a
    localparam logic [7:0] CH_LC = 8'h63; // c
    localparam logic [7:0] CH_UC = 8'h43; // C
    localparam logic [7:0] CH_LS = 8'h73; // s
    localparam logic [7:0] CH_US = 8'h53; // S
    localparam logic [7:0] CH_LI = 8'h69; // i
    localparam logic [7:0] CH_UI = 8'h49; // I
    localparam logic [7:0] CH_LF = 8'h66; // f
    localparam logic [7:0] CH_UZ = 8'h5A; // Z
    localparam logic [7:0] CH_UH = 8'h48; // H
    localparam logic [7:0] CH_UB = 8'h42; // B

    typedef struct packed {
        logic [2:0] fixed_len;  // 0 when not a fixed-size type
        logic       is_string;
        logic       is_array;
        logic       elem_ok;    // valid array subtype
        logic [1:0] elem_shift; // log2 of element size
    } type_info_t;

endpackage

// ===== rtl/atip_type_dec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atip_type_dec
// Decodes a byte as a field type code and as an array subtype code.
// ----------------------------------------------------------------------------
module atip_type_dec
    import atip_pkg::*;
(
    input  logic [7:0] code,
    output type_info_t info
);

    always_comb begin
        info = '0;
        case (code)
            CH_UA, CH_LA: begin
                info.fixed_len = 3'd1;
            end
            CH_LC, CH_UC: begin
                info.fixed_len  = 3'd1;
                info.elem_ok    = 1'b1;
                info.elem_shift = 2'd0;
            end
            CH_LS, CH_US: begin
                info.fixed_len  = 3'd2;
                info.elem_ok    = 1'b1;
                info.elem_shift = 2'd1;
            end
            CH_LI, CH_UI, CH_LF: begin
                info.fixed_len  = 3'd4;
                info.elem_ok    = 1'b1;
                info.elem_shift = 2'd2;
            end
            CH_UZ, CH_UH: begin
                info.is_string = 1'b1;
            end
            CH_UB: begin
                info.is_array = 1'b1;
            end
            default: begin
                info = '0;
            end
        endcase
    end

endmodule

// ===== rtl/aux_tag_index_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aux_tag_index_parser
// Walks the aux section of an alignment record byte by byte and reports the
// tag code and type-byte offset of each field, plus end and error results.
//
// s_ channel: one aux byte per beat in s_tdata, s_tlast on the section's
// final byte. m_ channel: zero or one result per input beat; m_tuser holds
// the result kind, m_tdata the tag code and type offset (both zero unless
// the kind is tag found).
// Throughput: one byte per cycle while s_tready is high; the phase machine
// and counters update from each accepted beat.
// Output: a result appears on m_ in the cycle after the beat that causes it,
// held in the output register until taken.
// Stall: s_tready is low only while the output register holds a result
// that m_tready has not taken; a taken result frees it in the same cycle.
// Reset: aresetn low returns the parser to expect a first name byte at
// offset zero and drops any pending result.
// ----------------------------------------------------------------------------
module aux_tag_index_parser
    import atip_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,  // [7:0] aux_byte
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TAG_W+POS_W-1:0]  m_tdata,  // [15:0] tag_code, [47:16] type_offset
    output logic [KIND_W-1:0]       m_tuser   // [2:0] result_kind
);

    typedef enum logic [2:0] {
        PH_NAME0,
        PH_NAME1,
        PH_TYPE,
        PH_SKIP,
        PH_STRING,
        PH_SUBTYPE,
        PH_COUNT
    } phase_t;

    phase_t            phase_reg,  phase_next;
    logic [7:0]        first_reg,  first_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [SKIP_W-1:0] skip_reg,   skip_next;
    logic [1:0]        shift_reg,  shift_next;
    logic [1:0]        cidx_reg,   cidx_next;
    logic [23:0]       acc_reg,    acc_next;
    logic              err_reg,    err_next;

    logic              m_tvalid_reg;
    logic [TAG_W+POS_W-1:0] m_tdata_reg;
    logic [KIND_W-1:0] m_tuser_reg;

    logic              accept;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [POS_W-1:0]  off;
    logic [POS_W-1:0]  pos_inc;
    logic [SKIP_W-1:0] skip_dec;
    logic [31:0]       count;
    type_info_t        info;

    atip_type_dec u_type_dec (
        .code (s_tdata),
        .info (info)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign pos_inc  = (pos_reg == {POS_W{1'b1}}) ? pos_reg : pos_reg + 1'b1;
    assign skip_dec = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;
    assign count    = {s_tdata, acc_reg};

    always_comb begin
        phase_next = phase_reg;
        first_next = first_reg;
        skip_next  = skip_reg;
        shift_next = shift_reg;
        cidx_next  = cidx_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        pos_next   = pos_inc;
        emit       = 1'b0;
        kind       = KIND_TAG;
        tag        = '0;
        off        = '0;

        if (!err_reg) begin
            case (phase_reg)
                PH_NAME0: begin
                    first_next = s_tdata;
                    phase_next = PH_NAME1;
                end
                PH_NAME1: begin
                    emit       = 1'b1;
                    kind       = KIND_TAG;
                    tag        = {first_reg, s_tdata};
                    off        = pos_inc;
                    phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    if (info.fixed_len != 3'd0) begin
                        skip_next  = {{(SKIP_W-3){1'b0}}, info.fixed_len};
                        phase_next = PH_SKIP;
                    end else if (info.is_string) begin
                        phase_next = PH_STRING;
                    end else if (info.is_array) begin
                        phase_next = PH_SUBTYPE;
                    end else begin
                        emit     = 1'b1;
                        kind     = KIND_BADTYPE;
                        err_next = 1'b1;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        phase_next = PH_NAME0;
                    end
                end
                PH_STRING: begin
                    if (s_tdata == 8'd0) begin
                        phase_next = PH_NAME0;
                    end
                end
                PH_SUBTYPE: begin
                    if (info.elem_ok) begin
                        shift_next = info.elem_shift;
                        cidx_next  = 2'd0;
                        acc_next   = '0;
                        phase_next = PH_COUNT;
                    end else begin
                        emit     = 1'b1;
                        kind     = KIND_BADSUB;
                        err_next = 1'b1;
                    end
                end
                PH_COUNT: begin
                    case (cidx_reg)
                        2'd0: acc_next[7:0]   = s_tdata;
                        2'd1: acc_next[15:8]  = s_tdata;
                        2'd2: acc_next[23:16] = s_tdata;
                        default: acc_next     = acc_reg;
                    endcase
                    if (cidx_reg == 2'd3) begin
                        cidx_next  = 2'd0;
                        skip_next  = {2'b00, count} << shift_reg;
                        phase_next = (count == '0) ? PH_NAME0 : PH_SKIP;
                    end else begin
                        cidx_next = cidx_reg + 2'd1;
                    end
                end
                default: begin
                    phase_next = PH_NAME0;
                end
            endcase
        end

        if (s_tlast) begin
            if (!err_reg && !err_next) begin
                emit = 1'b1;
                kind = (phase_next == PH_NAME0) ? KIND_END : KIND_TRUNC;
                tag  = '0;
                off  = '0;
            end
            phase_next = PH_NAME0;
            first_next = '0;
            pos_next   = '0;
            skip_next  = '0;
            shift_next = '0;
            cidx_next  = '0;
            acc_next   = '0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_NAME0;
            first_reg    <= '0;
            pos_reg      <= '0;
            skip_reg     <= '0;
            shift_reg    <= '0;
            cidx_reg     <= '0;
            acc_reg      <= '0;
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg    <= phase_next;
                first_reg    <= first_next;
                pos_reg      <= pos_next;
                skip_reg     <= skip_next;
                shift_reg    <= shift_next;
                cidx_reg     <= cidx_next;
                acc_reg      <= acc_next;
                err_reg      <= err_next;
                m_tvalid_reg <= emit;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_tdata_reg <= {off, tag};
            m_tuser_reg <= kind;
        end
    end

endmodule

// ===== sim/aux_tag_index_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aux_tag_index_checker
// Watches both channels of the aux tag index parser. A local parse model
// consumes every accepted input beat and queues the result it predicts.
// Each accepted output beat is compared field by field with the oldest
// queued result. Mismatches and unexpected beats are counted for the top.
// ----------------------------------------------------------------------------
module aux_tag_index_checker
    import atip_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [7:0]              s_tdata,  // [7:0] aux_byte
    input  logic                    s_tlast,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [TAG_W+POS_W-1:0]  m_tdata,  // [15:0] tag_code, [47:16] type_offset
    input  logic [KIND_W-1:0]       m_tuser,  // [2:0] result_kind
    output int unsigned             fail_count,
    output int unsigned             pending
);

    typedef enum logic [3:0] {
        PH_NAME0, PH_NAME1, PH_TYPE, PH_SKIP, PH_STRING, PH_SUBTYPE, PH_COUNT
    } parse_phase_e;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [POS_W-1:0]  offset;
    } aux_result_t;

    aux_result_t        result_q[$];

    parse_phase_e       phase;
    logic [7:0]         name0;
    logic [POS_W-1:0]   pos;
    logic [SKIP_W-1:0]  skip;
    logic [2:0]         esize;
    logic [1:0]         cidx;
    logic [31:0]        cacc;
    logic               err_latched;

    initial fail_count = 0;
    initial pending    = 0;

    function automatic logic [POS_W-1:0] sat_inc(logic [POS_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic clear_parse();
        phase       = PH_NAME0;
        name0       = '0;
        pos         = '0;
        skip        = '0;
        esize       = '0;
        cidx        = '0;
        cacc        = '0;
        err_latched = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output logic hit, output aux_result_t r);
        logic        was_err;
        logic [63:0] prod;
        was_err = err_latched;
        hit     = 1'b0;
        r       = '0;
        if (!was_err) begin
            case (phase)
                PH_NAME0: begin
                    name0 = b;
                    phase = PH_NAME1;
                end
                PH_NAME1: begin
                    hit      = 1'b1;
                    r.kind   = KIND_TAG;
                    r.tag    = {name0, b};
                    r.offset = sat_inc(pos);
                    phase    = PH_TYPE;
                end
                PH_TYPE: begin
                    if (b inside {CH_UA, CH_LA, CH_LC, CH_UC}) begin
                        skip  = 34'd1;
                        phase = PH_SKIP;
                    end else if (b inside {CH_LS, CH_US}) begin
                        skip  = 34'd2;
                        phase = PH_SKIP;
                    end else if (b inside {CH_LI, CH_UI, CH_LF}) begin
                        skip  = 34'd4;
                        phase = PH_SKIP;
                    end else if (b inside {CH_UZ, CH_UH}) begin
                        phase = PH_STRING;
                    end else if (b == CH_UB) begin
                        phase = PH_SUBTYPE;
                    end else begin
                        hit         = 1'b1;
                        r.kind      = KIND_BADTYPE;
                        err_latched = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (skip != 0) skip = skip - 1'b1;
                    if (skip == 0) phase = PH_NAME0;
                end
                PH_STRING: begin
                    if (b == 8'd0) phase = PH_NAME0;
                end
                PH_SUBTYPE: begin
                    if (b inside {CH_LC, CH_UC}) esize = 3'd1;
                    else if (b inside {CH_LS, CH_US}) esize = 3'd2;
                    else if (b inside {CH_LI, CH_UI, CH_LF}) esize = 3'd4;
                    else esize = 3'd0;
                    if (esize == 0) begin
                        hit         = 1'b1;
                        r.kind      = KIND_BADSUB;
                        err_latched = 1'b1;
                    end else begin
                        cidx  = '0;
                        cacc  = '0;
                        phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    cacc = cacc | ({24'd0, b} << (cidx * 8));
                    if (cidx == 2'd3) begin
                        cidx  = '0;
                        prod  = {32'd0, cacc} * {61'd0, esize};
                        skip  = prod[SKIP_W-1:0];
                        phase = (skip == 0) ? PH_NAME0 : PH_SKIP;
                    end else begin
                        cidx = cidx + 1'b1;
                    end
                end
                default: phase = PH_NAME0;
            endcase
        end
        pos = sat_inc(pos);
        if (last) begin
            if (!was_err && !err_latched) begin
                hit      = 1'b1;
                r.kind   = (phase == PH_NAME0) ? KIND_END : KIND_TRUNC;
                r.tag    = '0;
                r.offset = '0;
            end
            clear_parse();
        end
    endtask

    always @(posedge aclk) begin
        logic        hit;
        aux_result_t exp_r;
        aux_result_t got_r;
        if (!aresetn) begin
            clear_parse();
            result_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_r = {m_tuser, m_tdata[15:0], m_tdata[47:16]};
                if (result_q.size() == 0) begin
                    $error("unexpected result beat: result_kind %0d tag_code %h type_offset %0d",
                           got_r.kind, got_r.tag, got_r.offset);
                    fail_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (got_r.kind !== exp_r.kind) begin
                        $error("result_kind: expected %0d, actual %0d", exp_r.kind, got_r.kind);
                        fail_count++;
                    end
                    if (got_r.tag !== exp_r.tag) begin
                        $error("tag_code: expected %h, actual %h", exp_r.tag, got_r.tag);
                        fail_count++;
                    end
                    if (got_r.offset !== exp_r.offset) begin
                        $error("type_offset: expected %0d, actual %0d",
                               exp_r.offset, got_r.offset);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast, hit, exp_r);
                if (hit) result_q.insert(result_q.size(), exp_r);
            end
        end
        pending <= result_q.size();
    end

endmodule

// ===== sim/aux_tag_index_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aux_tag_index_parser_tb
// Stimulus and verdict for the aux tag index parser. A few directed sections
// hit the edge cases (extreme names, empty string and array, bad type, bad
// subtype on the last byte, truncation), then random sections follow: mostly
// well-formed fields of every type, plus truncated, broken and noise
// sections. Both sides idle at random; the result side also holds off for a
// long stretch and the input side once drains all pending results.
// ----------------------------------------------------------------------------
module aux_tag_index_parser_tb;
    import atip_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned RAND_BYTES  = 400;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = '0;  // [7:0] aux_byte
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TAG_W+POS_W-1:0] m_tdata;        // [15:0] tag_code, [47:16] type_offset
    logic [KIND_W-1:0]      m_tuser;        // [2:0] result_kind

    int unsigned fail_count;
    int unsigned pending;
    int unsigned sent_cnt  = 0;
    int unsigned cycle_cnt = 0;
    logic        hold_done = 1'b0;
    logic [7:0]  sect_q[$];
    wire         no_gap = (sent_cnt >= 250) && (sent_cnt < 330);

    aux_tag_index_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    aux_tag_index_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, one long hold-off, one stall-free window
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!hold_done && sent_cnt >= 80) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= no_gap || ($urandom_range(99) >= 38);
        end
    end

    function automatic logic [7:0] pick_type(int unsigned i);
        case (i)
            0:       return CH_UA;
            1:       return CH_LA;
            2:       return CH_LC;
            3:       return CH_UC;
            4:       return CH_LS;
            5:       return CH_US;
            6:       return CH_LI;
            7:       return CH_UI;
            8:       return CH_LF;
            9:       return CH_UZ;
            10:      return CH_UH;
            default: return CH_UB;
        endcase
    endfunction

    function automatic logic [7:0] pick_sub(int unsigned i);
        case (i)
            0:       return CH_LC;
            1:       return CH_UC;
            2:       return CH_LS;
            3:       return CH_US;
            4:       return CH_LI;
            5:       return CH_UI;
            default: return CH_LF;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_gap && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_cnt <= sent_cnt + 1;
    endtask

    task automatic send_section();
        for (int i = 0; i < sect_q.size(); i++)
            send_byte(sect_q[i], i == sect_q.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic append_byte(input logic [7:0] b);
        sect_q.insert(sect_q.size(), b);
    endtask

    task automatic add_name();
        append_byte(8'($urandom_range(255)));
        append_byte(8'($urandom_range(255)));
    endtask

    task automatic add_noise(int unsigned n);
        repeat (n) append_byte(8'($urandom_range(255)));
    endtask

    task automatic add_field();
        logic [7:0]  t;
        logic [7:0]  st;
        int unsigned cnt;
        int unsigned esz;
        add_name();
        t = pick_type($urandom_range(11));
        append_byte(t);
        if (t inside {CH_UA, CH_LA, CH_LC, CH_UC}) begin
            add_noise(1);
        end else if (t inside {CH_LS, CH_US}) begin
            add_noise(2);
        end else if (t inside {CH_LI, CH_UI, CH_LF}) begin
            add_noise(4);
        end else if (t inside {CH_UZ, CH_UH}) begin
            repeat ($urandom_range(6)) append_byte(8'($urandom_range(1, 255)));
            append_byte(8'd0);
        end else begin
            st  = pick_sub($urandom_range(6));
            esz = (st inside {CH_LC, CH_UC}) ? 1 : (st inside {CH_LS, CH_US}) ? 2 : 4;
            cnt = $urandom_range(5);
            append_byte(st);
            append_byte(8'(cnt));
            repeat (3) append_byte(8'd0);
            add_noise(cnt * esz);
        end
    endtask

    task automatic build_random_section();
        int unsigned sel;
        int unsigned keep;
        logic [7:0]  b;
        sect_q.delete();
        sel = $urandom_range(99);
        if (sel < 70) begin
            repeat ($urandom_range(1, 4)) add_field();
        end else if (sel < 80) begin
            repeat ($urandom_range(1, 3)) add_field();
            keep = $urandom_range(1, sect_q.size() - 1);
            while (sect_q.size() > keep) void'(sect_q.pop_back());
        end else if (sel < 88) begin
            repeat ($urandom_range(1)) add_field();
            add_name();
            do b = 8'($urandom_range(255));
            while (b inside {CH_UA, CH_LA, CH_LC, CH_UC, CH_LS, CH_US, CH_LI,
                             CH_UI, CH_LF, CH_UZ, CH_UH, CH_UB});
            append_byte(b);
            add_noise($urandom_range(4));
        end else if (sel < 95) begin
            repeat ($urandom_range(1)) add_field();
            add_name();
            append_byte(CH_UB);
            do b = 8'($urandom_range(255));
            while (b inside {CH_LC, CH_UC, CH_LS, CH_US, CH_LI, CH_UI, CH_LF});
            append_byte(b);
            add_noise($urandom_range(4));
        end else begin
            add_noise($urandom_range(1, 12));
        end
    endtask

    initial begin
        int unsigned rand_bytes;
        logic        paused;
        rand_bytes = 0;
        paused     = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extreme name bytes, clean end
        sect_q = '{8'hFF, 8'h00, CH_LC, 8'h7F};
        send_section();
        // empty string
        sect_q = '{8'h00, 8'hFF, CH_UZ, 8'h00};
        send_section();
        // empty array ends right after the count
        sect_q = '{8'h41, 8'h42, CH_UB, CH_UC, 8'h00, 8'h00, 8'h00, 8'h00};
        send_section();
        // unknown type, later bytes ignored
        sect_q = '{8'h78, 8'h79, 8'h71, 8'h7A, 8'h80};
        send_section();
        // unknown subtype on the final byte wins over truncation
        sect_q = '{8'h78, 8'h79, CH_UB, 8'h71};
        send_section();
        // final byte inside a value
        sect_q = '{8'h6B, 8'h6B, CH_LI, 8'h01};
        send_section();

        while (rand_bytes < RAND_BYTES) begin
            build_random_section();
            if (!paused && rand_bytes > 150) begin
                paused = 1'b1;
                wait_drained();
            end
            rand_bytes += sect_q.size();
            send_section();
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
